### src/adamax_pkg.sv
package adamax_pkg;

  localparam int FRAC_BITS = 24;

  // round(1e-7 * 2^FRAC_BITS), at least one LSB
  function automatic logic [30:0] eps_standin();
    logic [63:0] v;
    v = ((64'd1 << FRAC_BITS) + 64'd5000000) / 64'd10000000;
    return (v == 64'd0) ? 31'd1 : v[30:0];
  endfunction

  localparam logic [30:0] EPS_STANDIN = eps_standin();

  localparam logic [30:0] MAX_U31 = 31'h7FFF_FFFF;

  localparam int DIV_STAGES = 32;

  // register indexes
  localparam logic [2:0] REG_LR    = 3'd0;
  localparam logic [2:0] REG_BETA1 = 3'd1;
  localparam logic [2:0] REG_BETA2 = 3'd2;
  localparam logic [2:0] REG_EPS   = 3'd3;
  localparam logic [2:0] REG_ITER  = 3'd4;

  localparam logic [30:0] RST_LR    = 31'd16777;
  localparam logic [15:0] RST_BETA1 = 16'd58982;
  localparam logic [15:0] RST_BETA2 = 16'd65470;
  localparam logic [30:0] RST_EPS   = 31'd2;
  localparam logic [19:0] RST_ITER  = 20'd0;

  // one item inside the divider pipeline
  typedef struct packed {
    logic               valid;
    logic signed [31:0] nm;
    logic [30:0]        nu;
    logic               neg;
    logic               ov;
    logic [30:0]        rem;
    logic [31:0]        low;
  } div_t;

  typedef struct packed {
    logic signed [31:0] nm;
    logic [30:0]        nu;
    logic signed [31:0] upd;
  } res_t;

endpackage

### src/adamax_update.sv
// Pipeline: 4 arithmetic stages, 32 divider stages one quotient bit each and
// a 2-entry output buffer. Throughput: one beat per cycle while in_ready is
// high; output stall backs up after 2 buffered beats.
// After reset and after every config write in_ready stays low while the step
// scale is rebuilt (21 square/multiply, 63 divide steps).
// Reset: rst_n synchronous active low; registers load their default values.
module adamax_update import adamax_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_gradient,
  input  logic signed [31:0] in_prev_moment,
  input  logic [30:0]        in_prev_norm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_new_moment,
  output logic [30:0]        out_new_norm,
  output logic signed [31:0] out_update_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [30:0] lr_r;
  logic [15:0] b1_r;
  logic [15:0] b2_r;
  logic [30:0] eps_r;
  logic [19:0] iter_r;

  logic        busy;
  logic [30:0] scale;
  logic        adv;
  logic        full;
  logic        empty;
  logic        in_acc;
  div_t        front_out;
  div_t        div_out;
  res_t        res;
  logic [32:0] qmag;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= RST_LR;
      b1_r   <= RST_BETA1;
      b2_r   <= RST_BETA2;
      eps_r  <= RST_EPS;
      iter_r <= RST_ITER;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LR:    lr_r   <= cfg_data[30:0];
        REG_BETA1: b1_r   <= cfg_data[15:0];
        REG_BETA2: b2_r   <= cfg_data[15:0];
        REG_EPS:   eps_r  <= cfg_data[30:0];
        REG_ITER:  iter_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  adamax_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_valid),
    .lr    (lr_r),
    .b1    (b1_r),
    .eps   (eps_r),
    .iter  (iter_r),
    .scale (scale),
    .busy  (busy)
  );

  assign adv      = !full || out_ready;
  assign in_ready = adv && !busy;
  assign in_acc   = in_valid && in_ready;

  adamax_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .in_acc      (in_acc),
    .gradient    (in_gradient),
    .prev_moment (in_prev_moment),
    .prev_norm   (in_prev_norm),
    .b1          (b1_r),
    .b2          (b2_r),
    .scale       (scale),
    .dout        (front_out)
  );

  adamax_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .din   (front_out),
    .dout  (div_out)
  );

  always_comb begin
    qmag   = div_out.ov ? 33'h1_0000_0000 : {1'b0, div_out.low};
    res.nm = div_out.nm;
    res.nu = div_out.nu;
    if (div_out.neg) begin
      res.upd = (qmag > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-qmag);
    end else begin
      res.upd = (qmag > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(qmag);
    end
  end

  res_t ob_out;

  adamax_obuf u_obuf (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (adv && div_out.valid),
    .din   (res),
    .pop   (out_valid && out_ready),
    .full  (full),
    .empty (empty),
    .dout  (ob_out)
  );

  assign out_valid        = !empty;
  assign out_new_moment   = ob_out.nm;
  assign out_new_norm     = ob_out.nu;
  assign out_update_value = ob_out.upd;

endmodule

### src/adamax_scale.sv
module adamax_scale import adamax_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [30:0] lr,
  input  logic [15:0] b1,
  input  logic [30:0] eps,
  input  logic [19:0] iter,
  output logic [30:0] scale,
  output logic        busy
);

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_POW   = 6'b000010,
    ST_DINIT = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_DFIN  = 6'b010000,
    ST_DONE  = 6'b100000
  } st_t;

  st_t         state_r;
  logic [31:0] base_r;
  logic [31:0] pw_r;
  logic        pw_one_r;
  logic [20:0] e_r;
  logic [5:0]  cnt_r;
  logic [32:0] den_r;
  logic [32:0] rem_r;
  logic [62:0] num_r;
  logic [62:0] quo_r;
  logic [30:0] scale_r;

  logic [63:0] pw_prod;
  logic [63:0] base_prod;
  logic [30:0] eps_eff;
  logic [33:0] trial;
  logic        ge;
  logic [30:0] quo_sat;

  always_comb begin
    pw_prod   = 64'(pw_r) * 64'(base_r) + 64'h8000_0000;
    base_prod = 64'(base_r) * 64'(base_r) + 64'h8000_0000;
    eps_eff   = (eps == 31'd0) ? EPS_STANDIN : eps;
    trial     = {rem_r, num_r[62]};
    ge        = trial >= {1'b0, den_r};
    quo_sat   = (|quo_r[62:31]) ? MAX_U31 : quo_r[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else if (start) begin
      state_r <= ST_LOAD;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          base_r   <= {b1, 16'd0};
          pw_r     <= 32'd0;
          pw_one_r <= 1'b1;
          e_r      <= 21'(iter) + 21'd1;
          cnt_r    <= 6'd0;
          state_r  <= ST_POW;
        end
        ST_POW: begin
          // square and multiply, LSB of exponent first
          if (e_r[0]) begin
            pw_r     <= pw_one_r ? base_r : pw_prod[63:32];
            pw_one_r <= 1'b0;
          end
          base_r <= base_prod[63:32];
          e_r    <= e_r >> 1;
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'd20) begin
            state_r <= ST_DINIT;
          end
        end
        ST_DINIT: begin
          den_r <= pw_one_r ? 33'd0 : (33'h1_0000_0000 - {1'b0, pw_r});
          num_r <= {lr, 32'd0};
          rem_r <= 33'd0;
          quo_r <= 63'd0;
          cnt_r <= 6'd0;
          if (pw_one_r) begin
            scale_r <= eps_eff;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= ge ? 33'(trial - {1'b0, den_r}) : trial[32:0];
          num_r <= {num_r[61:0], 1'b0};
          quo_r <= {quo_r[61:0], ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd62) begin
            state_r <= ST_DFIN;
          end
        end
        ST_DFIN: begin
          scale_r <= (quo_sat == 31'd0) ? eps_eff : quo_sat;
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          state_r <= ST_DONE;
        end
        default: begin
          state_r <= ST_LOAD;
        end
      endcase
    end
  end

  assign scale = scale_r;
  assign busy  = (state_r != ST_DONE);

endmodule

### src/adamax_front.sv
module adamax_front import adamax_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_acc,
  input  logic signed [31:0] gradient,
  input  logic signed [31:0] prev_moment,
  input  logic [30:0]        prev_norm,
  input  logic [15:0]        b1,
  input  logic [15:0]        b2,
  input  logic [30:0]        scale,
  output div_t               dout
);

  // stage 1: beta products
  logic               v1_r;
  logic signed [48:0] pm_r;
  logic signed [49:0] pg_r;
  logic [46:0]        pu_r;
  logic [31:0]        ag_r;
  // stage 2: rounded moment and norm
  logic               v2_r;
  logic signed [31:0] nm2_r;
  logic [30:0]        nu2_r;
  // stage 3: moment times scale
  logic               v3_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] nm3_r;
  logic [30:0]        nu3_r;
  // stage 4: magnitude and overflow check
  div_t               d4_r;

  logic [16:0]        w1;
  logic signed [50:0] msum;
  logic signed [34:0] mrnd;
  logic signed [31:0] nm_sat;
  logic [31:0]        bu;
  logic [31:0]        mx;
  logic [32:0]        nu_inc;
  logic [30:0]        nu_sat;
  logic               pneg;
  logic [63:0]        pmag;

  always_comb begin
    w1   = 17'h1_0000 - {1'b0, b1};
    // round half up is floor((x + 2^15) / 2^16) for either sign
    msum = 51'(pm_r) + 51'(pg_r) + 51'sd32768;
    mrnd = 35'(msum >>> 16);
    if (mrnd > 35'sd2147483647) begin
      nm_sat = 32'sh7FFF_FFFF;
    end else if (mrnd < -35'sd2147483648) begin
      nm_sat = 32'sh8000_0000;
    end else begin
      nm_sat = mrnd[31:0];
    end
    bu     = 32'((pu_r + 47'd32768) >> 16);
    mx     = (bu > ag_r) ? bu : ag_r;
    nu_inc = {1'b0, mx} + 33'd1;
    nu_sat = (nu_inc > 33'(MAX_U31)) ? MAX_U31 : nu_inc[30:0];
    pneg   = prod_r[63];
    pmag   = pneg ? 64'(-prod_r) : 64'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      d4_r.valid <= 1'b0;
    end else if (adv) begin
      v1_r       <= in_acc;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      d4_r.valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm_r   <= $signed({1'b0, b1}) * prev_moment;
      pg_r   <= $signed({1'b0, w1}) * gradient;
      pu_r   <= {31'd0, b2} * {16'd0, prev_norm};
      ag_r   <= gradient[31] ? 32'(-gradient) : 32'(gradient);
      nm2_r  <= nm_sat;
      nu2_r  <= nu_sat;
      prod_r <= 64'(nm2_r) * $signed({33'd0, scale});
      nm3_r  <= nm2_r;
      nu3_r  <= nu2_r;
      d4_r.nm  <= nm3_r;
      d4_r.nu  <= nu3_r;
      d4_r.neg <= pneg;
      // quotient reaches 2^32 when the upper half alone covers the divisor
      d4_r.ov  <= {1'b0, pmag[61:32]} >= nu3_r;
      d4_r.rem <= {1'b0, pmag[61:32]};
      d4_r.low <= pmag[31:0];
    end
  end

  assign dout = d4_r;

endmodule

### src/adamax_div.sv
module adamax_div import adamax_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  div_t din,
  output div_t dout
);

  div_t st_r [DIV_STAGES];

  // one quotient bit; freed dividend bits take the quotient
  function automatic div_t div_step(div_t d);
    div_t        r;
    logic [31:0] t;
    logic        ge;
    r  = d;
    t  = {d.rem, d.low[31]};
    ge = t >= {1'b0, d.nu};
    r.rem = ge ? 31'(t - {1'b0, d.nu}) : t[30:0];
    r.low = {d.low[30:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st_r[k].valid <= 1'b0;
      end
    end else if (adv) begin
      st_r[0] <= div_step(din);
      for (int k = 1; k < DIV_STAGES; k++) begin
        st_r[k] <= div_step(st_r[k-1]);
      end
    end
  end

  assign dout = st_r[DIV_STAGES-1];

endmodule

### src/adamax_obuf.sv
module adamax_obuf import adamax_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  input  logic pop,
  output logic full,
  output logic empty,
  output res_t dout
);

  logic [1:0] cnt_r;
  res_t       d0_r;
  res_t       d1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        d0_r <= din;
      end else begin
        d0_r <= d1_r;
        d1_r <= din;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        d0_r <= din;
      end else begin
        d1_r <= din;
      end
    end else if (pop) begin
      d0_r <= d1_r;
    end
  end

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = d0_r;

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import adamax_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  // register index past the list, for the ignored-write case
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic signed [31:0] nm;
    logic [30:0]        nu;
    logic signed [31:0] upd;
  } adamax_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_gradient;
  logic signed [31:0] in_prev_moment;
  logic [30:0] in_prev_norm;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] out_new_moment;
  logic [30:0] out_new_norm;
  logic signed [31:0] out_update_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  adamax_update DUT (.*);

  // local copy of the register file
  logic [30:0] lr_q;
  logic [15:0] b1_q;
  logic [15:0] b2_q;
  logic [30:0] eps_q;
  logic [19:0] iter_q;
  logic [30:0] scale_q;

  adamax_res_t expected_updates[$];
  int errors;
  int beats_sent;
  int beats_checked;
  int idle_cycles;
  bit hold_out;
  bit stall_long;
  bit sender_bursty;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b + 128'h8000_0000;
    return p[95:32];
  endfunction

  function automatic logic [30:0] calc_scale();
    logic [20:0] e;
    logic [63:0] base;
    logic [63:0] pw;
    logic [63:0] d;
    logic [95:0] s;
    logic [30:0] eps;
    e = {1'b0, iter_q} + 21'd1;
    base = {32'd0, b1_q, 16'd0};
    pw = 64'h1_0000_0000;
    for (int i = 0; i < 21; i++) begin
      if (e[i]) pw = mul_q32(pw, base);
      base = mul_q32(base, base);
    end
    eps = (eps_q == 31'd0) ? EPS_STANDIN : eps_q;
    if (pw >= 64'h1_0000_0000) return eps;
    d = 64'h1_0000_0000 - pw;
    s = {33'd0, lr_q, 32'd0} / {32'd0, d};
    if (s > 96'(MAX_U31)) s = 96'(MAX_U31);
    if (s == 96'd0) return eps;
    return s[30:0];
  endfunction

  // signed x / 2^16, round half up
  function automatic logic signed [63:0] rnd16(logic signed [63:0] x);
    if (x >= 0) return (x + 64'sd32768) >>> 16;
    return -((-x + 64'sd32767) >>> 16);
  endfunction

  function automatic adamax_res_t calc_update(logic signed [31:0] g,
                                              logic signed [31:0] m,
                                              logic [30:0] u);
    adamax_res_t r;
    logic signed [63:0] nm;
    logic signed [63:0] bu;
    logic signed [63:0] ag;
    logic signed [63:0] nu;
    logic signed [95:0] prod;
    logic [95:0] mag;
    logic signed [95:0] q;
    nm = rnd16($signed({48'd0, b1_q}) * 64'(m)
               + (64'sd65536 - $signed({48'd0, b1_q})) * 64'(g));
    if (nm > 64'sd2147483647) nm = 64'sd2147483647;
    if (nm < -64'sd2147483648) nm = -64'sd2147483648;
    bu = rnd16($signed({48'd0, b2_q}) * $signed({33'd0, u}));
    ag = (g < 0) ? -64'(g) : 64'(g);
    nu = ((bu > ag) ? bu : ag) + 64'sd1;
    if (nu > 64'sd2147483647) nu = 64'sd2147483647;
    prod = 96'(nm) * $signed({65'd0, scale_q});
    mag = (prod < 0) ? 96'(-prod) : 96'(prod);
    mag = mag / 96'(nu);
    if (mag > 96'h1_0000_0000) mag = 96'h1_0000_0000;
    q = (prod < 0) ? -$signed(mag) : $signed(mag);
    if (q > 96'sd2147483647) q = 96'sd2147483647;
    if (q < -96'sd2147483648) q = -96'sd2147483648;
    r.nm = nm[31:0];
    r.nu = nu[30:0];
    r.upd = q[31:0];
    return r;
  endfunction

  // receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n || stall_long) out_ready <= 1'b0;
    else if (hold_out) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    adamax_res_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (expected_updates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat nm=%0d nu=%0d upd=%0d", $time,
                 out_new_moment, out_new_norm, out_update_value);
      end else begin
        want = expected_updates.pop_front();
        if (out_new_moment !== want.nm) begin
          errors++;
          $display("%0t: new_moment exp %0d got %0d", $time, want.nm, out_new_moment);
        end
        if (out_new_norm !== want.nu) begin
          errors++;
          $display("%0t: new_norm exp %0d got %0d", $time, want.nu, out_new_norm);
        end
        if (out_update_value !== want.upd) begin
          errors++;
          $display("%0t: update_value exp %0d got %0d", $time, want.upd,
                   out_update_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("%0t: watchdog expired, %0d results pending", $time,
               expected_updates.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_item(logic signed [31:0] g, logic signed [31:0] m,
                           logic [30:0] u);
    in_valid <= 1'b1;
    in_gradient <= g;
    in_prev_moment <= m;
    in_prev_norm <= u;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_updates.push_back(calc_update(g, m, u));
    beats_sent++;
    if (sender_bursty && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_input();
    while (expected_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LR:    lr_q = data[30:0];
      REG_BETA1: b1_q = data[15:0];
      REG_BETA2: b2_q = data[15:0];
      REG_EPS:   eps_q = data[30:0];
      REG_ITER:  iter_q = data[19:0];
      default: ;
    endcase
    scale_q = calc_scale();
    @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2,
                         logic [31:0] eps, logic [31:0] it);
    wait_drained();
    write_reg(REG_LR, lr);
    write_reg(REG_BETA1, b1);
    write_reg(REG_BETA2, b2);
    write_reg(REG_EPS, eps);
    write_reg(REG_ITER, it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255);
      3: return -$urandom_range(0, 255);
      4: return $urandom() >>> $urandom_range(0, 24);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random(int n);
    logic [31:0] g;
    logic [31:0] m;
    logic [31:0] u;
    for (int i = 0; i < n; i++) begin
      g = rand_word();
      m = rand_word();
      u = rand_word();
      send_item(g, m, u[30:0]);
    end
  endtask

  task automatic test_defaults();
    send_item(32'sh0100_0000, 32'sh0080_0000, 31'h0100_0000);
    send_item(0, 0, 0);
    send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    send_item(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
    send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
    send_item(-1, 1, 1);
    send_item(1, -1, 31'h4000_0000);
    send_item(32'shFFFF_0000, 32'sh0001_0000, 31'h55);
  endtask

  task automatic test_special_cases();
    // beta1 zero, max lr: scale equals lr, the largest value
    set_all(32'h7FFF_FFFF, 0, 65535, 5, 0);
    send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF);
    send_item(-5, 7, 3);
    // zero lr forces the fallback scale
    set_all(0, 40000, 0, 12345, 3);
    send_item(32'sh1000_0000, -3, 0);
    // fallback of zero uses the built-in stand-in
    set_all(0, 65535, 65535, 0, 20'hFFFFF);
    send_item(32'sh0123_4567, 32'sh7654_3210, 31'h1);
    send_item(32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF);
    // out-of-list write and masked wide data
    wait_drained();
    write_reg(REG_NONE, 32'hDEAD_BEEF);
    write_reg(REG_BETA1, 32'hFFFF_1234);
    write_reg(REG_LR, 32'hFFFF_FFFF);
    write_reg(REG_EPS, 32'hFFFF_FFFF);
    write_reg(REG_ITER, 32'hFFFF_FFFF);
    send_item(32'sh0ABC_DEF0, 32'shF000_0001, 31'h0000_1000);
    send_item(1, 1, 1);
  endtask

  task automatic test_random_configs();
    for (int ph = 0; ph < 8; ph++) begin
      set_all($urandom(), $urandom(), $urandom(), $urandom_range(0, 1) ? 0 : $urandom(),
              $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 40));
      send_random(120);
    end
  endtask

  task automatic test_backpressure();
    set_all(RST_LR, RST_BETA1, RST_BETA2, RST_EPS, RST_ITER);
    stall_long = 1'b1;
    fork
      send_random(40);
      begin
        repeat (300) @(posedge clk);
        stall_long = 1'b0;
      end
    join
    // pause until empty, then a no-idle stretch
    wait_drained();
    hold_out = 1'b1;
    sender_bursty = 1'b0;
    send_random(150);
    hold_out = 1'b0;
    sender_bursty = 1'b1;
    send_random(50);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_gradient = '0;
    in_prev_moment = '0;
    in_prev_norm = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    idle_cycles = 0;
    hold_out = 1'b0;
    stall_long = 1'b0;
    sender_bursty = 1'b1;
    lr_q = RST_LR;
    b1_q = RST_BETA1;
    b2_q = RST_BETA2;
    eps_q = RST_EPS;
    iter_q = RST_ITER;
    scale_q = calc_scale();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_special_cases();
    test_random_configs();
    test_backpressure();
    wait_drained();
    $display("Sent %0d items, checked %0d results over 14 register settings,",
             beats_sent, beats_checked);
    $display("including saturation, fallback scale and long output stalls.");
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
